[design/tcfh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfh_pkg
// Shared types, constants and MD5 tables for the fingerprint hasher.
// ----------------------------------------------------------------------------
package tcfh_pkg;

  localparam int unsigned MaxCiphers    = 32;
  localparam int unsigned MaxExtensions = 16;
  localparam int unsigned CipherCntW    = $clog2(MaxCiphers + 1);
  localparam int unsigned ExtCntW       = $clog2(MaxExtensions + 1);

  localparam logic [31:0] SessionSalt = 32'hEB9FAD55;
  localparam logic [31:0] ResetBlk0   = 32'he95534fc;
  localparam logic [31:0] ResetBlk1   = 32'h5bdd63a7;
  localparam logic [31:0] ResetBlk2   = 32'h53b688a2;
  localparam logic [31:0] ResetBlk3   = 32'hfcb20b47;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hefcdab89;
  localparam logic [31:0] Iv2 = 32'h98badcfe;
  localparam logic [31:0] Iv3 = 32'h10325476;

  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [1:0] CmdVersion = 2'd0;
  localparam logic [1:0] CmdCipher  = 2'd1;
  localparam logic [1:0] CmdExt     = 2'd2;
  localparam logic [1:0] CmdFinish  = 2'd3;

  localparam logic [1:0] RegBlk0 = 2'd0;
  localparam logic [1:0] RegBlk1 = 2'd1;
  localparam logic [1:0] RegBlk2 = 2'd2;
  localparam logic [1:0] RegBlk3 = 2'd3;

  localparam logic [2:0] LastPlace = 3'd4;
  localparam logic [3:0] FinZeroFill = 4'd5;
  localparam logic [3:0] FinLenLo    = 4'd6;
  localparam logic [3:0] FinLenHi    = 4'd7;
  localparam logic [3:0] FinTail     = 4'd8;
  localparam logic [5:0] LenSlot     = 6'd56;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEP, ST_DEC, ST_FIN, ST_RD, ST_RND, ST_FOLD, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_ACCEPT, OP_SEP, OP_DEC, OP_FIN, OP_RD, OP_RND, OP_FOLD, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic wrap;
    logic dec_last;
    logic fin_last;
    logic full;
    logic rnd_last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(({2'b00, i} << 2) + {2'b00, i} + 8'd1);
      2'd2: g = 4'(({2'b00, i} << 1) + {2'b00, i} + 8'd5);
      default: g = 4'(({2'b00, i} << 3) - {2'b00, i});
    endcase
    return g;
  endfunction

  function automatic logic [16:0] dec_pow(input logic [2:0] place);
    logic [16:0] p;
    unique case (place)
      3'd0: p = 17'd10000;
      3'd1: p = 17'd1000;
      3'd2: p = 17'd100;
      3'd3: p = 17'd10;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

endpackage

[design/tcfh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfh_ctrl
// Sequencer: item intake, byte emission phases, MD5 block runs, result load.
// ----------------------------------------------------------------------------
module tcfh_ctrl import tcfh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] cmd_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_i)
            CmdVersion: state_d = ST_DEC;
            CmdCipher, CmdExt: state_d = status_i.full ? ST_IDLE : ST_SEP;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_SEP: begin
        if (status_i.wrap) begin
          state_d = ST_RD;
          ret_d   = ST_DEC;
        end else begin
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        if (status_i.wrap) begin
          state_d = ST_RD;
          ret_d   = status_i.dec_last ? ST_IDLE : ST_DEC;
        end else if (status_i.dec_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (status_i.wrap) begin
          state_d = ST_RD;
          ret_d   = status_i.fin_last ? ST_OUT : ST_FIN;
        end
      end
      ST_RD:   state_d = ST_RND;
      ST_RND:  if (status_i.rnd_last) state_d = ST_FOLD;
      ST_FOLD: state_d = ret_q;
      ST_OUT:  if (!status_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_ACCEPT;
      end
      ST_SEP:  cmd_o.op = OP_SEP;
      ST_DEC:  cmd_o.op = OP_DEC;
      ST_FIN:  cmd_o.op = OP_FIN;
      ST_RD:   cmd_o.op = OP_RD;
      ST_RND:  cmd_o.op = OP_RND;
      ST_FOLD: cmd_o.op = OP_FOLD;
      ST_OUT:  if (!status_i.out_busy) cmd_o.op = OP_OUT;
      default: cmd_o.op = OP_NOP;
    endcase
  end

endmodule

[design/tcfh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfh_dp
// Datapath: text byte generation, block buffer, MD5 round unit, result regs.
// ----------------------------------------------------------------------------
module tcfh_dp import tcfh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  logic [1:0]  cmd_in_i,
  input  logic [15:0] value_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        verdict_o,
  output logic [31:0] session_key_o,
  output logic [31:0] digest_w0_o,
  output logic [31:0] digest_w1_o,
  output logic [31:0] digest_w2_o,
  output logic [31:0] digest_w3_o,
  output logic        list_overflow_o
);

  logic [31:0] blk_q [4];
  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] mem_q [16];
  logic [31:0] rd_q;
  logic [9:0]  len_q;
  logic [CipherCntW-1:0] cseen_q;
  logic [ExtCntW-1:0]    eseen_q;
  logic        ovf_q;
  logic        is_cipher_q;
  logic [15:0] rem_q;
  logic [2:0]  place_q;
  logic        started_q;
  logic [3:0]  phase_q;
  logic [12:0] bits_q;
  logic [5:0]  rnd_q;
  logic [31:0] key_q;
  logic        out_valid_q;

  logic        push;
  logic [7:0]  pbyte;
  logic [16:0] pw;
  logic [3:0]  dig;
  logic [16:0] dig_val;
  logic        emit;
  logic [31:0] f, sum, rot;
  logic [63:0] rot2;
  logic [31:0] sw [4];
  logic        match;

  always_comb begin
    pw  = dec_pow(place_q);
    dig = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, rem_q} >= 17'(k) * pw) dig = 4'(k);
    end
    dig_val = 17'(dig) * pw;
    emit    = (dig != 4'd0) || started_q || (place_q == LastPlace);
  end

  always_comb begin
    push  = 1'b0;
    pbyte = 8'h00;
    case (cmd_i.op)
      OP_SEP: begin
        push  = 1'b1;
        pbyte = (is_cipher_q ? (cseen_q == '0) : (eseen_q == '0)) ? ChComma : ChDash;
      end
      OP_DEC: begin
        push  = emit;
        pbyte = ChZero | {4'h0, dig};
      end
      OP_FIN: begin
        case (phase_q)
          4'd0, 4'd2: begin push = 1'b1; pbyte = ChComma; end
          4'd1, 4'd3: begin push = 1'b1; pbyte = ChZero; end
          4'd4: begin push = 1'b1; pbyte = PadMark; end
          FinZeroFill: push = (len_q[5:0] != LenSlot);
          FinLenLo: begin push = 1'b1; pbyte = bits_q[7:0]; end
          FinLenHi: begin push = 1'b1; pbyte = {3'b000, bits_q[12:8]}; end
          default: push = 1'b1;
        endcase
      end
      default: push = 1'b0;
    endcase
  end

  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (d_q & b_q) | (~d_q & c_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    sum  = a_q + f + md5_k(rnd_q) + rd_q;
    rot2 = {sum, sum} << md5_rot(rnd_q);
    rot  = rot2[63:32];
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < 4; i++) begin
      sw[i] = {chain_q[i][7:0], chain_q[i][15:8], chain_q[i][23:16], chain_q[i][31:24]};
      if (sw[i] != blk_q[i]) match = 1'b0;
    end
  end

  assign status_o.wrap     = push && (len_q[5:0] == 6'd63);
  assign status_o.dec_last = (place_q == LastPlace);
  assign status_o.fin_last = (phase_q == FinTail);
  assign status_o.full     = (cmd_in_i == CmdCipher) ?
                             (cseen_q >= CipherCntW'(MaxCiphers)) :
                             (eseen_q >= ExtCntW'(MaxExtensions));
  assign status_o.rnd_last = (rnd_q == 6'd63);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[len_q[5:2]][len_q[1:0]*8 +: 8] <= pbyte;
    if (cmd_i.op == OP_RD) rd_q <= mem_q[md5_g(6'd0)];
    else if (cmd_i.op == OP_RND) rd_q <= mem_q[md5_g(rnd_q + 6'd1)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT) begin
      rem_q       <= value_i;
      is_cipher_q <= (cmd_in_i == CmdCipher);
      key_q       <= SessionSalt ^ source_address_i ^ dest_address_i ^
                     {16'h0, source_port_i} ^ {16'h0, dest_port_i};
    end else if (cmd_i.op == OP_DEC) begin
      rem_q <= 16'({1'b0, rem_q} - dig_val);
    end
    if (cmd_i.op == OP_FIN && phase_q == 4'd4) bits_q <= {len_q, 3'b000};
    if (cmd_i.op == OP_RD) begin
      a_q <= chain_q[0]; b_q <= chain_q[1]; c_q <= chain_q[2]; d_q <= chain_q[3];
    end else if (cmd_i.op == OP_RND) begin
      a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
    end
    if (cmd_i.op == OP_OUT) begin
      verdict_o       <= !match;
      session_key_o   <= key_q;
      digest_w0_o     <= sw[0];
      digest_w1_o     <= sw[1];
      digest_w2_o     <= sw[2];
      digest_w3_o     <= sw[3];
      list_overflow_o <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q[0]    <= ResetBlk0;
      blk_q[1]    <= ResetBlk1;
      blk_q[2]    <= ResetBlk2;
      blk_q[3]    <= ResetBlk3;
      chain_q[0]  <= Iv0;
      chain_q[1]  <= Iv1;
      chain_q[2]  <= Iv2;
      chain_q[3]  <= Iv3;
      len_q       <= '0;
      cseen_q     <= '0;
      eseen_q     <= '0;
      ovf_q       <= 1'b0;
      place_q     <= '0;
      started_q   <= 1'b0;
      phase_q     <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegBlk0: blk_q[0] <= cfg_data_i;
          RegBlk1: blk_q[1] <= cfg_data_i;
          RegBlk2: blk_q[2] <= cfg_data_i;
          RegBlk3: blk_q[3] <= cfg_data_i;
          default: blk_q[0] <= cfg_data_i;
        endcase
      end
      if (push) len_q <= len_q + 10'd1;
      if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_ACCEPT: begin
          place_q   <= '0;
          started_q <= 1'b0;
          phase_q   <= '0;
          if (cmd_in_i == CmdVersion) begin
            chain_q[0] <= Iv0; chain_q[1] <= Iv1; chain_q[2] <= Iv2; chain_q[3] <= Iv3;
            len_q   <= '0;
            cseen_q <= '0;
            eseen_q <= '0;
            ovf_q   <= 1'b0;
          end else if ((cmd_in_i == CmdCipher || cmd_in_i == CmdExt) && status_o.full) begin
            ovf_q <= 1'b1;
          end
        end
        OP_SEP: begin
          if (is_cipher_q) cseen_q <= cseen_q + 1'b1;
          else eseen_q <= eseen_q + 1'b1;
        end
        OP_DEC: begin
          place_q <= place_q + 3'd1;
          if (emit) started_q <= 1'b1;
        end
        OP_FIN: begin
          if (phase_q < FinZeroFill) phase_q <= phase_q + 4'd1;
          else if (phase_q == FinZeroFill) begin
            if (len_q[5:0] == LenSlot) phase_q <= FinLenLo;
          end else if (phase_q != FinTail) phase_q <= phase_q + 4'd1;
        end
        OP_RD: rnd_q <= '0;
        OP_RND: rnd_q <= rnd_q + 6'd1;
        OP_FOLD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
        end
        OP_OUT: begin
          out_valid_q <= 1'b1;
          chain_q[0] <= Iv0; chain_q[1] <= Iv1; chain_q[2] <= Iv2; chain_q[3] <= Iv3;
          len_q   <= '0;
          cseen_q <= '0;
          eseen_q <= '0;
          ovf_q   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/tls_client_fingerprint_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_client_fingerprint_hash
// JA3-style fingerprint text builder with an MD5 engine and block verdict.
// ----------------------------------------------------------------------------
// Input beats carry cmd/value (version, cipher, extension, finish) plus the
// connection tuple, which is only used on finish. A version beat emits up to
// five digit bytes, a cipher or extension beat a separator and up to five
// digits, at one byte per cycle except while a block runs, into a 64-byte
// block buffer; a full block runs the MD5 compression on one shared round
// unit (one read setup, 64 rounds, one chain fold). A cipher or extension
// beat is dropped when its list is full. A finish beat appends ",0,0" and
// the padding, one or two blocks.
// One beat is worked on at a time; in_ready_o is high only between beats.
// Only finish produces an output beat, held in an output register until
// taken; a later beat is accepted meanwhile and only a second finish waits
// for the register to drain. Config writes (cfg_index_i 0..3 = blocked
// digest words) are taken every cycle and belong between records.
// Reset loads the MD5 initial chain, clears counts and loads the default
// blocked digest; no output beat is pending after reset.
// ----------------------------------------------------------------------------
module tls_client_fingerprint_hash import tcfh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] value_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        verdict_o,
  output logic [31:0] session_key_o,
  output logic [31:0] digest_w0_o,
  output logic [31:0] digest_w1_o,
  output logic [31:0] digest_w2_o,
  output logic [31:0] digest_w3_o,
  output logic        list_overflow_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  tcfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  tcfh_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .status_o         (dp_status),
    .cmd_in_i         (cmd_i),
    .value_i          (value_i),
    .source_address_i (source_address_i),
    .dest_address_i   (dest_address_i),
    .source_port_i    (source_port_i),
    .dest_port_i      (dest_port_i),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .verdict_o        (verdict_o),
    .session_key_o    (session_key_o),
    .digest_w0_o      (digest_w0_o),
    .digest_w1_o      (digest_w1_o),
    .digest_w2_o      (digest_w2_o),
    .digest_w3_o      (digest_w3_o),
    .list_overflow_o  (list_overflow_o)
  );

endmodule
